### rtl/sync_length_frame_receiver_crc16_top_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the frame receiver checker
// clocked on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_FRAME_RECEIVER_CRC16_TOP_MACROS_SVH
`define SYNC_LENGTH_FRAME_RECEIVER_CRC16_TOP_MACROS_SVH

// consequent checked in the same cycle
`define SLFR_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame receiver check failed");

// consequent checked in the next cycle
`define SLFR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame receiver check failed");

`endif

### rtl/slfr_pkg.sv
// ----------------------------------------------------------------------------
// slfr_pkg
// shared constants, job types and crc step for the frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package slfr_pkg;

  localparam int MAX_FRAME_DEF = 64;
  localparam int BYTE_W        = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
  localparam logic [7:0]  MIN_LEN       = 8'd10;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam logic [15:0] TICKS_MAX     = 16'hFFFF;
  localparam logic [1:0]  SYNC_NEEDED   = 2'd2;
  localparam logic [1:0]  SYNC_MAX      = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SUM     = 3'd1;
  localparam logic [2:0] ST_CRC     = 3'd2;
  localparam logic [2:0] ST_LEN     = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;

  // one unit of work for the back end
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] fbyte;
    logic [7:0] len;
    logic       bank;
  } job_t;

  // back end hands a drained frame bank back to the front end
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  // reflected crc-16, one byte, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/slfr_ifs.sv
// ----------------------------------------------------------------------------
// slfr channel interfaces
// valid/ready channels for incoming items and result items
// ----------------------------------------------------------------------------
`default_nettype none

interface slfr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, mode, rx_byte, input ready);
  modport sink (input valid, mode, rx_byte, output ready);
endinterface

interface slfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [5:0] byte_index;
  logic       last;
  logic [2:0] status;

  modport source (output valid, frame_byte, byte_index, last, status, input ready);
  modport sink (input valid, frame_byte, byte_index, last, status, output ready);
endinterface

`default_nettype wire

### rtl/sync_length_frame_receiver_crc16_top.sv
// ----------------------------------------------------------------------------
// sync_length_frame_receiver_crc16_top
// length-prefixed serial frame receiver with 8-bit sum and crc-16 check
// ----------------------------------------------------------------------------
// Each input item is either a received byte (mode 0) or a time tick (mode 1).
// The front end takes one item per clock whenever it is ready: it hunts for
// two or more 0xFF bytes and a length byte L (10 to MAX_FRAME-3), writes the
// L+3 frame bytes into a frame bank, keeps the sum and crc-16/arc on the fly
// and checks them against the trailing bytes, and watches for a timeout from
// the start of the frame. Every outcome that produces results becomes a job
// in a two-entry queue. The back end turns a status job into one result item
// (last set) and drains a good frame as L result items, index 0 being the
// length byte, one at a time: in S_READ it loads the result register from the
// registered ram read while the read address moves on, and in S_WAIT it waits
// until the item is handed over. The store holds two frame banks, so the
// next frame fills while the previous one drains; the front end stalls only
// when both banks still wait to be drained or the queue is full. The store
// needs no clearing pass after reset. timeout_ticks resets to 500 and is
// written through cfg_wr_en and cfg_wr_data; the user must write it only
// while the block is idle, the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_length_frame_receiver_crc16_top
  import slfr_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  slfr_in_if.sink     items,
  slfr_out_if.source  results
);

  // one bank is MAX_FRAME rounded up to a power of two, two banks in the store
  localparam int PW = $clog2(MAX_FRAME);
  localparam int AW = PW + 1;

  // front end to queue
  logic q_push;
  job_t q_push_job;
  logic q_full;

  // queue to back end
  logic q_pop;
  logic q_empty;
  job_t q_head;

  // store ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // bank hand-back from back end to front end
  release_t rel;

  slfr_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .items       (items),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (q_push_job),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .rel         (rel)
  );

  // job queue, lets the front keep taking bytes while results back up
  slfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // frame store, two banks
  slfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (2 ** AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  slfr_back #(
    .MAX_FRAME (MAX_FRAME)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .rel       (rel),
    .results   (results)
  );

endmodule

`default_nettype wire

### rtl/slfr_ram.sv
// ----------------------------------------------------------------------------
// slfr_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module slfr_ram
  import slfr_pkg::*;
#(
  parameter int WIDTH = BYTE_W,
  parameter int DEPTH = 2 * MAX_FRAME_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/slfr_front.sv
// ----------------------------------------------------------------------------
// slfr_front
// header hunt, frame fill, sum and crc check, job generation
// ----------------------------------------------------------------------------
`default_nettype none

module slfr_front
  import slfr_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF,
  localparam int PW = $clog2(MAX_FRAME),
  localparam int AW = PW + 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [15:0]   cfg_wr_data,
  slfr_in_if.sink       items,
  input  logic          q_full,
  output logic          q_push,
  output job_t          q_job,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [7:0]    ram_wdata,
  input  release_t      rel
);

  localparam logic [7:0] LEN_MAX = 8'(MAX_FRAME - 3);

  logic [15:0]   timeout_ticks;
  logic [1:0]    sync_count, sync_count_next;
  logic          in_frame, in_frame_next;
  logic [7:0]    len, len_next;
  logic [PW-1:0] pos, pos_next;
  logic [7:0]    running_sum, running_sum_next;
  logic [15:0]   running_crc, running_crc_next;
  logic [15:0]   elapsed, elapsed_next;
  logic          sum_ok, sum_ok_next;
  logic          crc_hi_ok, crc_hi_ok_next;
  logic          bank, bank_next;
  logic [1:0]    busy, busy_next;
  logic          accept;

  assign items.ready = !q_full && !busy[bank];
  assign accept      = items.valid && items.ready;
  assign ram_wdata   = items.rx_byte;

  always_comb begin
    logic [15:0] elapsed_inc;
    logic [8:0]  pos_e;
    logic [8:0]  len_e;
    logic        hunt;
    logic        crc_ok;

    elapsed_inc = (elapsed != TICKS_MAX) ? elapsed + 16'd1 : elapsed;
    pos_e       = 9'(pos);
    len_e       = {1'b0, len};
    hunt        = 1'b0;
    crc_ok      = 1'b0;

    sync_count_next  = sync_count;
    in_frame_next    = in_frame;
    len_next         = len;
    pos_next         = pos;
    running_sum_next = running_sum;
    running_crc_next = running_crc;
    elapsed_next     = elapsed;
    sum_ok_next      = sum_ok;
    crc_hi_ok_next   = crc_hi_ok;
    bank_next        = bank;
    busy_next        = busy;
    q_push           = 1'b0;
    q_job            = '{status: ST_OK, fbyte: 8'h00, len: len, bank: bank};
    ram_we           = 1'b0;
    ram_waddr        = {bank, pos};

    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end

    if (accept) begin
      if (items.mode) begin
        // tick: only counts while a frame is open
        if (in_frame) begin
          elapsed_next = elapsed_inc;
          if (elapsed_inc > timeout_ticks) begin
            q_push       = 1'b1;
            q_job.status = ST_TIMEOUT;
            hunt         = 1'b1;
          end
        end
      end else if (!in_frame) begin
        if (items.rx_byte == SYNC_BYTE) begin
          sync_count_next = (sync_count == SYNC_MAX) ? sync_count : sync_count + 2'd1;
        end else if (sync_count >= SYNC_NEEDED) begin
          sync_count_next = 2'd0;
          if (items.rx_byte >= MIN_LEN && items.rx_byte <= LEN_MAX) begin
            in_frame_next    = 1'b1;
            len_next         = items.rx_byte;
            running_sum_next = items.rx_byte;
            running_crc_next = crc_byte(16'h0000, items.rx_byte);
            pos_next         = PW'(1);
            elapsed_next     = 16'd0;
            ram_we           = 1'b1;
            ram_waddr        = {bank, PW'(0)};
          end else begin
            q_push       = 1'b1;
            q_job.status = ST_LEN;
            q_job.fbyte  = items.rx_byte;
          end
        end else begin
          sync_count_next = 2'd0;
        end
      end else begin
        ram_we   = 1'b1;
        pos_next = pos + PW'(1);
        if (pos_e < len_e) begin
          running_sum_next = running_sum + items.rx_byte;
          running_crc_next = crc_byte(running_crc, items.rx_byte);
        end
        if (pos_e == len_e) begin
          sum_ok_next = (running_sum == items.rx_byte);
        end
        if (pos_e == len_e + 9'd1) begin
          crc_hi_ok_next = (running_crc[15:8] == items.rx_byte);
        end
        if (pos_e == len_e + 9'd2) begin
          crc_ok = crc_hi_ok && (running_crc[7:0] == items.rx_byte);
          q_push = 1'b1;
          hunt   = 1'b1;
          if (!sum_ok) begin
            q_job.status = ST_SUM;
          end else if (!crc_ok) begin
            q_job.status = ST_CRC;
          end else begin
            // frame bytes stay in this bank until the back end drains them
            q_job.status    = ST_OK;
            busy_next[bank] = 1'b1;
            bank_next       = !bank;
          end
        end
      end
    end

    if (hunt) begin
      in_frame_next    = 1'b0;
      pos_next         = '0;
      running_sum_next = 8'h00;
      running_crc_next = 16'h0000;
      elapsed_next     = 16'd0;
      sync_count_next  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      sync_count    <= 2'd0;
      in_frame      <= 1'b0;
      len           <= 8'h00;
      pos           <= '0;
      running_sum   <= 8'h00;
      running_crc   <= 16'h0000;
      elapsed       <= 16'd0;
      sum_ok        <= 1'b0;
      crc_hi_ok     <= 1'b0;
      bank          <= 1'b0;
      busy          <= 2'b00;
    end else begin
      if (cfg_wr_en) begin
        timeout_ticks <= cfg_wr_data;
      end
      sync_count  <= sync_count_next;
      in_frame    <= in_frame_next;
      len         <= len_next;
      pos         <= pos_next;
      running_sum <= running_sum_next;
      running_crc <= running_crc_next;
      elapsed     <= elapsed_next;
      sum_ok      <= sum_ok_next;
      crc_hi_ok   <= crc_hi_ok_next;
      bank        <= bank_next;
      busy        <= busy_next;
    end
  end

endmodule

`default_nettype wire

### rtl/slfr_queue.sv
// ----------------------------------------------------------------------------
// slfr_queue
// short job fifo between front end and back end
// ----------------------------------------------------------------------------
`default_nettype none

module slfr_queue
  import slfr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/slfr_back.sv
// ----------------------------------------------------------------------------
// slfr_back
// takes jobs, drains good frames from the store, drives the result register
// ----------------------------------------------------------------------------
`default_nettype none

module slfr_back
  import slfr_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF,
  localparam int PW = $clog2(MAX_FRAME),
  localparam int AW = PW + 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  job_t          q_head,
  output logic          q_pop,
  output logic [AW-1:0] ram_raddr,
  input  logic [7:0]    ram_rdata,
  output release_t      rel,
  slfr_out_if.source    results
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0] state, state_next;
  logic [7:0] idx, idx_next;
  logic [7:0] cur_len;
  logic       cur_bank;
  logic       out_valid;
  logic [7:0] out_byte;
  logic [5:0] out_index;
  logic       out_last;
  logic [2:0] out_status;
  logic       slot_free;
  logic       load_status;
  logic       load_data;
  logic       take_frame;
  logic       is_last;

  assign slot_free = !out_valid || results.ready;
  assign is_last   = (idx + 8'd1 == cur_len);

  assign results.valid      = out_valid;
  assign results.frame_byte = out_byte;
  assign results.byte_index = out_index;
  assign results.last       = out_last;
  assign results.status     = out_status;

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    q_pop       = 1'b0;
    rel         = '{valid: 1'b0, bank: cur_bank};
    ram_raddr   = {cur_bank, idx[PW-1:0]};
    load_status = 1'b0;
    load_data   = 1'b0;
    take_frame  = 1'b0;
    case (state)
      S_IDLE: begin
        if (!q_empty && slot_free) begin
          q_pop = 1'b1;
          if (q_head.status != ST_OK) begin
            load_status = 1'b1;
          end else begin
            take_frame = 1'b1;
            ram_raddr  = {q_head.bank, PW'(0)};
            idx_next   = 8'd0;
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        // read data is here and the result register is known to be empty
        load_data = 1'b1;
        if (is_last) begin
          rel.valid  = 1'b1;
          state_next = S_IDLE;
        end else begin
          idx_next   = idx + 8'd1;
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (slot_free) begin
          state_next = S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (load_status || load_data) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_frame) begin
      cur_len  <= q_head.len;
      cur_bank <= q_head.bank;
    end
    if (load_status) begin
      out_byte   <= q_head.fbyte;
      out_index  <= 6'd0;
      out_last   <= 1'b1;
      out_status <= q_head.status;
    end else if (load_data) begin
      out_byte   <= ram_rdata;
      out_index  <= idx[5:0];
      out_last   <= is_last;
      out_status <= ST_OK;
    end
  end

endmodule

`default_nettype wire

### rtl/slfr_checker.sv
// ----------------------------------------------------------------------------
// slfr_checker
// port level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "sync_length_frame_receiver_crc16_top_macros.svh"

module slfr_checker
  import slfr_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] res_frame_byte,
  input logic [5:0] res_byte_index,
  input logic       res_last,
  input logic [2:0] res_status
);

  localparam logic [7:0] LEN_MAX = 8'(MAX_FRAME - 3);

  logic [17:0] res_payload;
  logic        res_no_byte;

  assign res_payload = {res_frame_byte, res_byte_index, res_last, res_status};
  assign res_no_byte = (res_status == ST_SUM) || (res_status == ST_CRC) ||
                       (res_status == ST_TIMEOUT);

  // stalled result holds
  `SLFR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_payload))

  // a status result is a run of its own
  `SLFR_ASSERT_SAME(a_status_single, res_valid && res_status != ST_OK, res_last && res_byte_index == 6'd0)

  // sum, crc and timeout results carry no byte
  `SLFR_ASSERT_SAME(a_status_zero, res_valid && res_no_byte, res_frame_byte == 8'h00)

  // bad length reports a length outside the accepted range
  `SLFR_ASSERT_SAME(a_len_range, res_valid && res_status == ST_LEN, res_frame_byte < MIN_LEN || res_frame_byte > LEN_MAX)

  // frame drain leaves a gap after each byte that is not the last
  `SLFR_ASSERT_NEXT(a_drain_gap, res_valid && res_ready && res_status == ST_OK && !res_last, !res_valid)

endmodule

bind sync_length_frame_receiver_crc16_top slfr_checker #(
  .MAX_FRAME (MAX_FRAME)
) u_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (results.valid),
  .res_ready      (results.ready),
  .res_frame_byte (results.frame_byte),
  .res_byte_index (results.byte_index),
  .res_last       (results.last),
  .res_status     (results.status)
);

`default_nettype wire
